### design/rtcbcd_pkg.sv
package rtcbcd_pkg;

	localparam logic [7:0] ANY_MARK  = 8'h80;
	localparam logic [7:0] KEEP_SEC  = 8'h7F;
	localparam logic [7:0] KEEP_H24  = 8'h3F;
	localparam logic [7:0] KEEP_H12  = 8'h1F;
	localparam logic [7:0] KEEP_WDAY = 8'h07;
	localparam logic [7:0] KEEP_DATE = 8'h3F;
	localparam logic [7:0] HOUR_12H  = 8'h40;
	localparam logic [7:0] HOUR_PM   = 8'h20;
	localparam logic [7:0] HOUR_NOON = 8'd12;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [1:0] HALF_NONE = 2'd0;
	localparam logic [1:0] HALF_AM   = 2'd1;
	localparam logic [1:0] HALF_PM   = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [55:0] packet_in;
		logic [7:0]  sec_in;
		logic [7:0]  min_in;
		logic [7:0]  hour24_in;
		logic [7:0]  hour12_in;
		logic        pm_in;
		logic [7:0]  weekday_in;
		logic [7:0]  date_in;
		logic [7:0]  month_in;
		logic [7:0]  year_in;
	} req_item_t;

	typedef struct packed {
		logic [55:0] packet_out;
		logic [7:0]  sec_out;
		logic [7:0]  min_out;
		logic [7:0]  hour24_out;
		logic [7:0]  hour12_out;
		logic [1:0]  half_day;
		logic [7:0]  weekday_out;
		logic [7:0]  date_out;
		logic [7:0]  month_out;
		logic [7:0]  year_out;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0] h24;
		logic [7:0] h12;
		logic [1:0] half;
	} hour_dec_t;

	// quotient by ten through reciprocal 205/2048, exact for all 8-bit values
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd205;
		return p[15:11];
	endfunction

	// tens digit above fifteen loses its high bits
	function automatic logic [7:0] bcd_pack(input logic [7:0] v);
		logic [4:0] q;
		logic [7:0] r;
		q = div10(v);
		r = v - ({q, 3'b000} + {2'b00, q, 1'b0});
		return {q[3:0], r[3:0]};
	endfunction

	function automatic logic [7:0] enc_masked(input logic [7:0] v, input logic [7:0] keep);
		logic [7:0] res;
		if (v[7]) begin
			res = ANY_MARK;
		end else begin
			res = bcd_pack(v) & keep;
		end
		return res;
	endfunction

	function automatic logic [7:0] bcd_unpack(input logic [7:0] b);
		return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
	endfunction

	function automatic logic [7:0] dec_masked(input logic [7:0] b, input logic [7:0] keep);
		logic [7:0] res;
		if (b[7]) begin
			res = ANY_MARK;
		end else begin
			res = bcd_unpack(b & keep);
		end
		return res;
	endfunction

	function automatic logic [7:0] enc_hour(input logic [7:0] h24, input logic [7:0] h12,
			input logic pm, input logic form24);
		logic [7:0] res;
		if (form24) begin
			res = enc_masked(h24, KEEP_H24);
		end else if (h12[7]) begin
			res = ANY_MARK;
		end else begin
			res = enc_masked(h12, KEEP_H12) | HOUR_12H | (pm ? HOUR_PM : 8'h00);
		end
		return res;
	endfunction

	function automatic hour_dec_t dec_hour(input logic [7:0] b);
		hour_dec_t  res;
		logic [7:0] v;
		v = 8'h00;
		if (b[7]) begin
			res.h24  = ANY_MARK;
			res.h12  = ANY_MARK;
			res.half = HALF_NONE;
		end else if ((b & HOUR_12H) != 8'h00) begin
			v = dec_masked(b, KEEP_H12);
			res.h12 = v;
			if ((b & HOUR_PM) != 8'h00) begin
				res.h24  = (v == HOUR_NOON) ? HOUR_NOON : HOUR_NOON + v;
				res.half = HALF_PM;
			end else begin
				res.h24  = (v == HOUR_NOON) ? 8'h00 : v;
				res.half = HALF_AM;
			end
		end else begin
			v = dec_masked(b, KEEP_H24);
			res.h24 = v;
			if (v == 8'h00) begin
				res.h12  = HOUR_NOON;
				res.half = HALF_AM;
			end else if (v == HOUR_NOON) begin
				res.h12  = HOUR_NOON;
				res.half = HALF_PM;
			end else if (v < HOUR_NOON) begin
				res.h12  = v;
				res.half = HALF_AM;
			end else begin
				res.h12  = v - HOUR_NOON;
				res.half = HALF_PM;
			end
		end
		return res;
	endfunction

endpackage

### design/rtcbcd_if.sv
interface rtcbcd_req_if;
	logic                  valid;
	logic                  ready;
	rtcbcd_pkg::req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtcbcd_rsp_if;
	logic                  valid;
	logic                  ready;
	rtcbcd_pkg::rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtcbcd_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/rtc_bcd_time_packet_codec_top.sv
// Converts RTC date/time between binary fields and the seven-byte BCD register packet
// (mode 0 encode, mode 1 decode). One item is taken every cycle unless rsp stalls;
// its result goes through the input register, then the result register, to rsp; a
// stalled result register holds back the input register and then the request channel.
// The cfg channel is always ready and sets 24-hour (1, reset value) or 12-hour AM/PM
// hour encoding; write it only while no item is in flight.
module rtc_bcd_time_packet_codec_top (
	input  logic          clk,
	input  logic          arst_n,
	rtcbcd_req_if.sink    req,
	rtcbcd_rsp_if.source  rsp,
	rtcbcd_cfg_if.sink    cfg
);

	logic                  write_24_hour_q;
	logic                  valid_s1;
	rtcbcd_pkg::req_item_t item_s1;
	logic                  rsp_valid_q;
	rtcbcd_pkg::rsp_item_t result_q;
	rtcbcd_pkg::rsp_item_t result_c;
	logic                  advance;
	logic                  take;

	assign cfg.ready = 1'b1;
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_24_hour_q <= 1'b1;
		end else if (cfg.valid) begin
			write_24_hour_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= req.data;
		end
		if (advance && valid_s1) begin
			result_q <= result_c;
		end
	end

	always_comb begin
		rtcbcd_pkg::hour_dec_t hd;
		logic [55:0]           p;
		result_c = '0;
		hd = rtcbcd_pkg::dec_hour(item_s1.packet_in[23:16]);
		p  = item_s1.packet_in;
		if (item_s1.mode == rtcbcd_pkg::MODE_ENCODE) begin
			result_c.packet_out = {
				rtcbcd_pkg::bcd_pack(item_s1.year_in),
				rtcbcd_pkg::enc_masked(item_s1.month_in, rtcbcd_pkg::KEEP_DATE),
				rtcbcd_pkg::enc_masked(item_s1.date_in, rtcbcd_pkg::KEEP_DATE),
				rtcbcd_pkg::enc_masked(item_s1.weekday_in, rtcbcd_pkg::KEEP_WDAY),
				rtcbcd_pkg::enc_hour(item_s1.hour24_in, item_s1.hour12_in, item_s1.pm_in,
					write_24_hour_q),
				rtcbcd_pkg::enc_masked(item_s1.min_in, rtcbcd_pkg::KEEP_SEC),
				rtcbcd_pkg::enc_masked(item_s1.sec_in, rtcbcd_pkg::KEEP_SEC)
			};
		end else begin
			result_c.sec_out     = rtcbcd_pkg::dec_masked(p[7:0], rtcbcd_pkg::KEEP_SEC);
			result_c.min_out     = rtcbcd_pkg::dec_masked(p[15:8], rtcbcd_pkg::KEEP_SEC);
			result_c.hour24_out  = hd.h24;
			result_c.hour12_out  = hd.h12;
			result_c.half_day    = hd.half;
			result_c.weekday_out = rtcbcd_pkg::dec_masked(p[31:24], rtcbcd_pkg::KEEP_WDAY);
			result_c.date_out    = rtcbcd_pkg::dec_masked(p[39:32], rtcbcd_pkg::KEEP_DATE);
			result_c.month_out   = rtcbcd_pkg::dec_masked(p[47:40], rtcbcd_pkg::KEEP_DATE);
			result_c.year_out    = rtcbcd_pkg::bcd_unpack(p[55:48]);
		end
	end

endmodule

### design/rtcbcd_chk.sv
module rtcbcd_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input rtcbcd_pkg::rsp_item_t rsp_data
);

	// hold a stalled item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result item changed while stalled");

	// an encoded packet never comes with decoded fields
	a_mode_split: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.packet_out != 56'd0 |->
			rsp_data.sec_out == 8'd0 && rsp_data.hour24_out == 8'd0 &&
			rsp_data.half_day == rtcbcd_pkg::HALF_NONE && rsp_data.year_out == 8'd0)
		else $error("packet and decoded fields both set");

	a_half_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.half_day == rtcbcd_pkg::HALF_NONE ||
			rsp_data.half_day == rtcbcd_pkg::HALF_AM ||
			rsp_data.half_day == rtcbcd_pkg::HALF_PM)
		else $error("bad half-day code");

	// an 'any' hour carries no AM/PM, and both hour forms agree on it
	a_any_hour: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.hour24_out == rtcbcd_pkg::ANY_MARK |->
			rsp_data.hour12_out == rtcbcd_pkg::ANY_MARK &&
			rsp_data.half_day == rtcbcd_pkg::HALF_NONE)
		else $error("inconsistent 'any' hour");

endmodule

bind rtc_bcd_time_packet_codec_top rtcbcd_chk u_rtcbcd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
